// File: rtl/core/gls_pkg.sv
`timescale 1ns / 1ps
// gls_pkg: shared types and constants for the grid laplacian stencil
// used by gls_grid_ram, gls_stencil_alu and grid_laplacian_stencil_top
// no dependencies
package gls_pkg;

  localparam int VALUE_W = 16;
  localparam int LAP_W   = 24;
  localparam int SCALE_W = 16;
  localparam int SUM_W   = 19;
  localparam int PROD_W  = 36;
  localparam int RND_W   = PROD_W - 8;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [1:0] MODE_ZERO_FLUX = 2'd0;
  localparam logic [1:0] MODE_PERIODIC  = 2'd1;
  localparam logic [1:0] MODE_MASKED    = 2'd2;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_MODE   = 2'd0;
  localparam reg_index_t REG_WIDTH  = 2'd1;
  localparam reg_index_t REG_HEIGHT = 2'd2;
  localparam reg_index_t REG_SCALE  = 2'd3;

  localparam logic signed [LAP_W-1:0] LAP_MAX = {1'b0, {(LAP_W-1){1'b1}}};
  localparam logic signed [LAP_W-1:0] LAP_MIN = {1'b1, {(LAP_W-1){1'b0}}};

  typedef struct packed {
    logic                      mask;
    logic signed [VALUE_W-1:0] value;
  } grid_entry_t;

  typedef enum logic [1:0] {
    AU_HOLD,
    AU_CLEAR,
    AU_ADD,
    AU_SCALE
  } au_op_t;

  typedef struct packed {
    au_op_t                    op;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] center;
    logic [SCALE_W-1:0]        scale;
  } au_ctrl_t;

  typedef struct packed {
    logic signed [LAP_W-1:0] lap;
    logic                    sat;
  } au_result_t;

endpackage

// File: rtl/core/gls_grid_ram.sv
`timescale 1ns / 1ps
// gls_grid_ram: single-port grid memory, value and mask bit per cell
// depends on gls_pkg
module gls_grid_ram #(
  parameter int DEPTH = 16384
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  gls_pkg::grid_entry_t       wdata,
  output gls_pkg::grid_entry_t       rdata
);
  import gls_pkg::*;

  grid_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/core/gls_stencil_alu.sv
`timescale 1ns / 1ps
// gls_stencil_alu: shared accumulate unit, scale multiply, round and clip
// depends on gls_pkg
module gls_stencil_alu (
  input  logic                  clk,
  input  gls_pkg::au_ctrl_t     ctrl,
  output gls_pkg::au_result_t   result
);
  import gls_pkg::*;

  logic signed [SUM_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  diff;
  logic signed [PROD_W-1:0] acc_ext;
  logic signed [PROD_W-1:0] scale_ext;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  rnd;

  // neighbour minus center, one used neighbour per step
  assign diff      = SUM_W'(ctrl.value) - SUM_W'(ctrl.center);
  assign acc_ext   = PROD_W'(acc);
  assign scale_ext = $signed({{(PROD_W-SCALE_W){1'b0}}, ctrl.scale});

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      AU_HOLD:  ;
      AU_CLEAR: acc <= '0;
      AU_ADD:   acc <= acc + diff;
      AU_SCALE: prod <= acc_ext * scale_ext;
      default:  ;
    endcase
  end

  // half up rounding from q.21 to q.13, then clip to the output range
  assign prod_rnd = prod + PROD_W'(128);
  assign rnd      = prod_rnd[PROD_W-1:8];

  always_comb begin
    unique if (rnd > RND_W'(LAP_MAX)) begin
      result.lap = LAP_MAX;
      result.sat = 1'b1;
    end else if (rnd < RND_W'(LAP_MIN)) begin
      result.lap = LAP_MIN;
      result.sat = 1'b1;
    end else begin
      result.lap = rnd[LAP_W-1:0];
      result.sat = 1'b0;
    end
  end

endmodule

// File: rtl/core/grid_laplacian_stencil_top.sv
`timescale 1ns / 1ps
// grid_laplacian_stencil_top: five-point laplacian over a stored grid
// depends on gls_pkg, gls_grid_ram, gls_stencil_alu
//
// A load item (operation 0) writes value and mask bit into the grid memory
// and returns an all-zero result on done in the next cycle; loads, and
// computes at cells outside the grid in use, are taken one per cycle and
// never raise busy. A compute item inside the grid raises busy, and its
// result shows on done in the cycle busy falls, where the next item may
// already be started. Busy covers the five reads (center, then north,
// south, west, east) through the single port of the grid memory, whose
// read data is registered, then the tail, multiply and round-and-clip states.
// The result is held on the ports for exactly one cycle with done high; the
// receiver cannot stall it. Configuration writes are taken whenever busy is
// low (cfg_ready). The grid memory has no reset: every cell a compute reaches
// must have been loaded first.
module grid_laplacian_stencil_top #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  logic [6:0]            row,
  input  logic [6:0]            col,
  input  logic signed [15:0]    cell_value,
  input  logic                  cell_mask,
  output logic                  done,
  output logic signed [23:0]    laplacian,
  output logic                  cell_is_masked,
  output logic                  saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  gls_pkg::reg_index_t   cfg_index,
  input  logic [15:0]           cfg_data
);
  import gls_pkg::*;

  localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int ADDR_CALC_W = AW + 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TAIL,
    S_SCALE,
    S_ROUND
  } state_t;

  // configuration registers
  logic [1:0]  boundary_mode;
  logic [7:0]  grid_width;
  logic [7:0]  grid_height;
  logic [15:0] inv_dx_squared;

  // sequencer state and captured item
  state_t      state;
  logic [2:0]  step;
  logic [7:0]  ctr_row;
  logic [7:0]  ctr_col;
  logic [7:0]  nb_row [4];
  logic [7:0]  nb_col [4];
  logic [3:0]  nb_use;
  logic signed [VALUE_W-1:0] cur;
  logic        cur_mask;

  // grid size in use and geometry of an incoming item
  logic [7:0]  w_use;
  logic [7:0]  h_use;
  logic [7:0]  r8;
  logic [7:0]  c8;
  logic        in_grid;
  logic        in_storage;
  logic        accept;
  logic        mask_mode;
  logic [7:0]  geo_row [4];
  logic [7:0]  geo_col [4];
  logic [3:0]  geo_use;

  // memory port
  logic        ram_en;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  grid_entry_t ram_wdata;
  grid_entry_t ram_rdata;
  logic [7:0]  sel_row;
  logic [7:0]  sel_col;
  logic [1:0]  rd_idx;

  // shared arithmetic unit
  au_ctrl_t    au_ctrl;
  au_result_t  au_res;
  logic [1:0]  cons_idx;
  logic        nb_used;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign mask_mode = (boundary_mode == MODE_MASKED);

  // configuration port, written only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_mode  <= MODE_ZERO_FLUX;
      grid_width     <= 8'd128;
      grid_height    <= 8'd128;
      inv_dx_squared <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   boundary_mode  <= cfg_data[1:0];
        REG_WIDTH:  grid_width     <= cfg_data[7:0];
        REG_HEIGHT: grid_height    <= cfg_data[7:0];
        REG_SCALE:  inv_dx_squared <= cfg_data;
        default:    ;
      endcase
    end
  end

  // clamp the grid size to [2, storage size]
  always_comb begin
    priority if (grid_width < 8'd2) begin
      w_use = 8'd2;
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_use = 8'(MAX_WIDTH);
    end else begin
      w_use = grid_width;
    end
    priority if (grid_height < 8'd2) begin
      h_use = 8'd2;
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_use = 8'(MAX_HEIGHT);
    end else begin
      h_use = grid_height;
    end
  end

  assign r8         = {1'b0, row};
  assign c8         = {1'b0, col};
  assign in_grid    = (r8 < h_use) && (c8 < w_use);
  assign in_storage = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);

  // neighbour coordinates, order north, south, west, east;
  // an unusable neighbour points at the center to keep the address in range
  always_comb begin
    if (boundary_mode == MODE_PERIODIC) begin
      geo_use    = 4'b1111;
      geo_row[0] = (r8 == 8'd0) ? h_use - 8'd1 : r8 - 8'd1;
      geo_row[1] = (r8 + 8'd1 >= h_use) ? 8'd0 : r8 + 8'd1;
      geo_col[2] = (c8 == 8'd0) ? w_use - 8'd1 : c8 - 8'd1;
      geo_col[3] = (c8 + 8'd1 >= w_use) ? 8'd0 : c8 + 8'd1;
    end else begin
      geo_use[0] = (r8 != 8'd0);
      geo_use[1] = (r8 + 8'd1 < h_use);
      geo_use[2] = (c8 != 8'd0);
      geo_use[3] = (c8 + 8'd1 < w_use);
      geo_row[0] = geo_use[0] ? r8 - 8'd1 : r8;
      geo_row[1] = geo_use[1] ? r8 + 8'd1 : r8;
      geo_col[2] = geo_use[2] ? c8 - 8'd1 : c8;
      geo_col[3] = geo_use[3] ? c8 + 8'd1 : c8;
    end
    geo_col[0] = c8;
    geo_col[1] = c8;
    geo_row[2] = r8;
    geo_row[3] = r8;
  end

  // memory address: load cell while idle, else the cell of this read step
  assign rd_idx = 2'(step - 3'd1);

  always_comb begin
    if (state == S_IDLE) begin
      sel_row = r8;
      sel_col = c8;
    end else if (step == 3'd0) begin
      sel_row = ctr_row;
      sel_col = ctr_col;
    end else begin
      sel_row = nb_row[rd_idx];
      sel_col = nb_col[rd_idx];
    end
  end

  assign ram_addr = AW'(ADDR_CALC_W'(sel_row) * ADDR_CALC_W'(MAX_WIDTH)
                        + ADDR_CALC_W'(sel_col));
  assign ram_we   = (state == S_IDLE) && accept && (operation == OP_LOAD) && in_storage;
  assign ram_en   = ram_we || (state == S_READ);
  assign ram_wdata.mask  = cell_mask;
  assign ram_wdata.value = cell_value;

  gls_grid_ram #(
    .DEPTH (GRID_DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // read data of step k arrives in step k+1; neighbours are consumed from
  // step 2 on, the east one in the tail cycle
  assign cons_idx = (state == S_TAIL) ? 2'd3 : 2'(step - 3'd2);
  assign nb_used  = nb_use[cons_idx] && !(mask_mode && ram_rdata.mask);

  always_comb begin
    au_ctrl.op     = AU_HOLD;
    au_ctrl.value  = ram_rdata.value;
    au_ctrl.center = cur;
    au_ctrl.scale  = inv_dx_squared;
    unique case (state)
      S_IDLE: begin
        if (accept && (operation == OP_COMPUTE) && in_grid) begin
          au_ctrl.op = AU_CLEAR;
        end
      end
      S_READ: begin
        if ((step >= 3'd2) && nb_used) begin
          au_ctrl.op = AU_ADD;
        end
      end
      S_TAIL: begin
        if (nb_used) begin
          au_ctrl.op = AU_ADD;
        end
      end
      S_SCALE: au_ctrl.op = AU_SCALE;
      S_ROUND: au_ctrl.op = AU_HOLD;
      default: au_ctrl.op = AU_HOLD;
    endcase
  end

  gls_stencil_alu u_alu (
    .clk    (clk),
    .ctrl   (au_ctrl),
    .result (au_res)
  );

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((operation == OP_COMPUTE) && in_grid) begin
              state   <= S_READ;
              step    <= 3'd0;
              ctr_row <= r8;
              ctr_col <= c8;
              nb_use  <= geo_use;
              for (int i = 0; i < 4; i++) begin
                nb_row[i] <= geo_row[i];
                nb_col[i] <= geo_col[i];
              end
            end else begin
              // load, or compute outside the grid in use
              done           <= 1'b1;
              laplacian      <= '0;
              cell_is_masked <= 1'b0;
              saturated      <= 1'b0;
            end
          end
        end
        S_READ: begin
          if (step == 3'd1) begin
            cur      <= ram_rdata.value;
            cur_mask <= ram_rdata.mask;
          end
          if (step == 3'd4) begin
            state <= S_TAIL;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_TAIL: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (mask_mode && cur_mask) begin
            laplacian      <= '0;
            cell_is_masked <= 1'b1;
            saturated      <= 1'b0;
          end else begin
            laplacian      <= au_res.lap;
            cell_is_masked <= 1'b0;
            saturated      <= au_res.sat;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result is only ever presented once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  // a load always answers in the next cycle with an all-zero result
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_LOAD)) |=>
      (done && (laplacian == '0) && !saturated && !cell_is_masked))
    else $error("load did not return a zero result");

  // a masked cell reports zero and no clipping
  a_masked_zero: assert property (@(posedge clk) disable iff (rst)
    (done && cell_is_masked) |-> ((laplacian == '0) && !saturated))
    else $error("masked cell with nonzero result");

  // read step counter stays within the five grid reads
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (step <= 3'd4))
    else $error("read step out of range");
`endif

endmodule
